>>> rtl/qapm_pkg.sv
// ----------------------------------------------------------------------------
// qapm_pkg
// Shared widths, register indexes, gain/config structs and the motor clamp
// for the quadcopter attitude PID and motor mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

  localparam int TIME_W    = 32;
  localparam int THR_W     = 12;
  localparam int ANG_W     = 16;
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 24;
  localparam int PERIOD_W  = 16;
  localparam int PROD_W    = 42;  // 25-bit signed gain x 17-bit error
  localparam int INTEG_W   = 40;
  localparam int SUM_W     = 44;
  localparam int FRAC_W    = 20;
  localparam int PID_W     = 24;
  localparam int MIX_W     = 27;
  localparam int MOTOR_W   = 11;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP_RP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_RP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_RP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_YAW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_YAW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_YAW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd6;

  // register reset values
  localparam logic [GAIN_W-1:0]   KP_RESET     = 24'd144179;
  localparam logic [GAIN_W-1:0]   KI_RP_RESET  = 24'd721;
  localparam logic [GAIN_W-1:0]   KD_RESET     = 24'd1310720;
  localparam logic [GAIN_W-1:0]   KI_YAW_RESET = 24'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

  localparam logic [MOTOR_W-1:0] MOTOR_MIN    = 11'd1000;
  localparam logic [MOTOR_W-1:0] MOTOR_MAX    = 11'd2000;
  localparam logic [THR_W-1:0]   THROTTLE_ARM = 12'd1100;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    gains_t              rp;
    gains_t              yaw;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  // clamp a mixed motor value to the pulse range, idle on low throttle
  function automatic logic [MOTOR_W-1:0] motor_clamp(input logic signed [MIX_W-1:0] v,
                                                     input logic low);
    logic [MOTOR_W-1:0] res;
    if (low) begin
      res = MOTOR_MIN;
    end else if (v < $signed({16'd0, MOTOR_MIN})) begin
      res = MOTOR_MIN;
    end else if (v > $signed({16'd0, MOTOR_MAX})) begin
      res = MOTOR_MAX;
    end else begin
      res = v[MOTOR_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/qapm_if.sv
// ----------------------------------------------------------------------------
// qapm_if
// Valid/ready channel interfaces: sensor request in, motor result out and
// the configuration write channel.
// ----------------------------------------------------------------------------
interface qapm_in_if;
  logic                                valid;
  logic                                ready;
  logic [qapm_pkg::TIME_W-1:0]         now_ms;
  logic [qapm_pkg::THR_W-1:0]          throttle;
  logic signed [qapm_pkg::ANG_W-1:0]   pitch_setpoint;
  logic signed [qapm_pkg::ANG_W-1:0]   roll_setpoint;
  logic signed [qapm_pkg::ANG_W-1:0]   yaw_setpoint;
  logic signed [qapm_pkg::ANG_W-1:0]   pitch_angle;
  logic signed [qapm_pkg::ANG_W-1:0]   roll_angle;
  logic signed [qapm_pkg::ANG_W-1:0]   yaw_angle;

  modport source (output valid, now_ms, throttle, pitch_setpoint, roll_setpoint,
                  yaw_setpoint, pitch_angle, roll_angle, yaw_angle, input ready);
  modport sink (input valid, now_ms, throttle, pitch_setpoint, roll_setpoint,
                yaw_setpoint, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

interface qapm_out_if;
  logic                           valid;
  logic                           ready;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_one;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_two;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_three;
  logic [qapm_pkg::MOTOR_W-1:0]   motor_four;
  logic                           control_updated;

  modport source (output valid, motor_one, motor_two, motor_three, motor_four,
                  control_updated, input ready);
  modport sink (input valid, motor_one, motor_two, motor_three, motor_four,
                control_updated, output ready);
endinterface

interface qapm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [qapm_pkg::CFG_IDX_W-1:0]   index;
  logic [qapm_pkg::GAIN_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/quad_attitude_pid_mixer_top.sv
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer_top
// Quadcopter X-frame attitude PID (pitch, roll, yaw) with four-motor mixer.
// ----------------------------------------------------------------------------
// The block takes one sensor request per cycle while no stage stalls and
// presents one motor result per request, produced by an input register, a gain
// product stage (three 25x17 multipliers per axis), a PID update stage that
// reads and writes the axis state, and the mixer feeding the result register.
// The PID update stage is the only place the timestamp, integrators and held
// outputs change, so back-to-back requests see each other's updates in order.
// Each stage holds while the one behind it is full and stalled; requests are
// still taken while a finished result waits, as long as a stage is free.
// The config channel is always ready; write gains only while no request is
// in flight.
module quad_attitude_pid_mixer_top (
  input  logic               clk,
  input  logic               rst_n,
  qapm_in_if.sink            in_ch,
  qapm_out_if.source         out_ch,
  qapm_cfg_if.sink           cfg_ch
);

  qapm_pkg::cfg_t cfg;

  // stage valids and advance strobes
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_go, s2_go, s3_go, in_acc;

  // input register
  logic [qapm_pkg::TIME_W-1:0]        s1_now_r;
  logic [qapm_pkg::THR_W-1:0]         s1_thr_r;
  logic signed [qapm_pkg::ANG_W-1:0]  s1_psp_r, s1_rsp_r, s1_ysp_r;
  logic signed [qapm_pkg::ANG_W-1:0]  s1_pang_r, s1_rang_r, s1_yang_r;

  // product stage and mixer stage sidebands
  logic [qapm_pkg::TIME_W-1:0] s2_now_r;
  logic [qapm_pkg::THR_W-1:0]  s2_thr_r, s3_thr_r;
  logic                        s3_upd_r;

  logic [qapm_pkg::TIME_W-1:0] last_time_r;
  logic [qapm_pkg::TIME_W-1:0] elapsed;
  logic                        upd, commit;

  logic signed [qapm_pkg::PID_W-1:0] pid_pitch, pid_roll, pid_yaw;

  // pipeline flow control
  assign s3_go  = s3_v_r && (!out_v_r || out_ch.ready);
  assign s2_go  = s2_v_r && (!s3_v_r || s3_go);
  assign s1_go  = s1_v_r && (!s2_v_r || s2_go);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) s1_v_r <= 1'b1;
      else if (s1_go) s1_v_r <= 1'b0;
      if (s1_go) s2_v_r <= 1'b1;
      else if (s2_go) s2_v_r <= 1'b0;
      if (s2_go) s3_v_r <= 1'b1;
      else if (s3_go) s3_v_r <= 1'b0;
      if (s3_go) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  // request capture and sideband pipeline
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r  <= in_ch.now_ms;
      s1_thr_r  <= in_ch.throttle;
      s1_psp_r  <= in_ch.pitch_setpoint;
      s1_rsp_r  <= in_ch.roll_setpoint;
      s1_ysp_r  <= in_ch.yaw_setpoint;
      s1_pang_r <= in_ch.pitch_angle;
      s1_rang_r <= in_ch.roll_angle;
      s1_yang_r <= in_ch.yaw_angle;
    end
    if (s1_go) begin
      s2_now_r <= s1_now_r;
      s2_thr_r <= s1_thr_r;
    end
    if (s2_go) begin
      s3_thr_r <= s2_thr_r;
      s3_upd_r <= upd;
    end
  end

  // sample period check, wraps modulo 2^32
  assign elapsed = s2_now_r - last_time_r;
  assign upd     = elapsed >= qapm_pkg::TIME_W'(cfg.period);
  assign commit  = s2_go && upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
    end else if (commit) begin
      last_time_r <= s2_now_r;
    end
  end

  // config register bank
  assign cfg_ch.ready = 1'b1;

  qapm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // per-axis PID
  qapm_axis_pid u_pitch (
    .clk (clk), .rst_n (rst_n), .load_prod (s1_go), .commit (commit),
    .gains (cfg.rp), .setpoint (s1_psp_r), .angle (s1_pang_r), .pid_out (pid_pitch)
  );

  qapm_axis_pid u_roll (
    .clk (clk), .rst_n (rst_n), .load_prod (s1_go), .commit (commit),
    .gains (cfg.rp), .setpoint (s1_rsp_r), .angle (s1_rang_r), .pid_out (pid_roll)
  );

  qapm_axis_pid u_yaw (
    .clk (clk), .rst_n (rst_n), .load_prod (s1_go), .commit (commit),
    .gains (cfg.yaw), .setpoint (s1_ysp_r), .angle (s1_yang_r), .pid_out (pid_yaw)
  );

  // mixer and result register
  qapm_mixer u_mixer (
    .clk             (clk),
    .load            (s3_go),
    .throttle        (s3_thr_r),
    .updated         (s3_upd_r),
    .pid_pitch       (pid_pitch),
    .pid_roll        (pid_roll),
    .pid_yaw         (pid_yaw),
    .motor_one       (out_ch.motor_one),
    .motor_two       (out_ch.motor_two),
    .motor_three     (out_ch.motor_three),
    .motor_four      (out_ch.motor_four),
    .control_updated (out_ch.control_updated)
  );

  assign out_ch.valid = out_v_r;

  // a full, stalled pipeline must refuse new requests
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && s3_v_r && out_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("request accepted into a full stalled pipeline");

  // timestamp only moves on a committed PID update
  a_time_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && !$stable(last_time_r)) |-> $past(commit))
    else $error("update timestamp changed without a PID update");

  // a PID update always produces a result flagged as updated
  a_upd_flag: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (s3_v_r && s3_upd_r))
    else $error("PID update not carried to the mixer stage");

  // every delivered motor value is within the pulse range
  a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_ch.motor_one >= qapm_pkg::MOTOR_MIN
              && out_ch.motor_one <= qapm_pkg::MOTOR_MAX
              && out_ch.motor_two >= qapm_pkg::MOTOR_MIN
              && out_ch.motor_two <= qapm_pkg::MOTOR_MAX
              && out_ch.motor_three >= qapm_pkg::MOTOR_MIN
              && out_ch.motor_three <= qapm_pkg::MOTOR_MAX
              && out_ch.motor_four >= qapm_pkg::MOTOR_MIN
              && out_ch.motor_four <= qapm_pkg::MOTOR_MAX))
    else $error("motor pulse width out of range");

endmodule

>>> rtl/qapm_cfg_regs.sv
// ----------------------------------------------------------------------------
// qapm_cfg_regs
// Gain and sample period register bank, written through the config channel.
// ----------------------------------------------------------------------------
module qapm_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [qapm_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [qapm_pkg::GAIN_W-1:0]    wr_data,
  output qapm_pkg::cfg_t     cfg
);

  qapm_pkg::cfg_t cfg_r;

  // register write decode; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rp.kp   <= qapm_pkg::KP_RESET;
      cfg_r.rp.ki   <= qapm_pkg::KI_RP_RESET;
      cfg_r.rp.kd   <= qapm_pkg::KD_RESET;
      cfg_r.yaw.kp  <= qapm_pkg::KP_RESET;
      cfg_r.yaw.ki  <= qapm_pkg::KI_YAW_RESET;
      cfg_r.yaw.kd  <= qapm_pkg::KD_RESET;
      cfg_r.period  <= qapm_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        qapm_pkg::REG_KP_RP:  cfg_r.rp.kp  <= wr_data;
        qapm_pkg::REG_KI_RP:  cfg_r.rp.ki  <= wr_data;
        qapm_pkg::REG_KD_RP:  cfg_r.rp.kd  <= wr_data;
        qapm_pkg::REG_KP_YAW: cfg_r.yaw.kp <= wr_data;
        qapm_pkg::REG_KI_YAW: cfg_r.yaw.ki <= wr_data;
        qapm_pkg::REG_KD_YAW: cfg_r.yaw.kd <= wr_data;
        qapm_pkg::REG_PERIOD: cfg_r.period <= wr_data[qapm_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/qapm_axis_pid.sv
// ----------------------------------------------------------------------------
// qapm_axis_pid
// One PID axis: error and gain products in a product stage, then integrator,
// derivative, truncation and saturation in the update stage.
// ----------------------------------------------------------------------------
module qapm_axis_pid (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load_prod,
  input  logic                               commit,
  input  qapm_pkg::gains_t                   gains,
  input  logic signed [qapm_pkg::ANG_W-1:0]  setpoint,
  input  logic signed [qapm_pkg::ANG_W-1:0]  angle,
  output logic signed [qapm_pkg::PID_W-1:0]  pid_out
);

  localparam int IW = qapm_pkg::INTEG_W;
  localparam int SW = qapm_pkg::SUM_W;
  localparam int PW = qapm_pkg::PID_W;
  localparam int FW = qapm_pkg::FRAC_W;

  logic signed [qapm_pkg::ERR_W-1:0]  err;
  logic signed [qapm_pkg::PROD_W-1:0] kp_e, ki_e, kd_e, kdl_prod;

  logic signed [qapm_pkg::ERR_W-1:0]  err_r;
  logic signed [qapm_pkg::PROD_W-1:0] kp_e_r, ki_e_r, kd_e_r;

  logic signed [IW-1:0]               integ_r, integ_nxt;
  logic signed [qapm_pkg::ERR_W-1:0]  last_err_r;
  logic signed [qapm_pkg::PROD_W-1:0] kdl_r, kdl_nxt;
  logic signed [PW-1:0]               pid_r, pid_nxt;

  logic signed [IW+2:0]               integ_sum;
  logic signed [SW-1:0]               pid_sum, pid_bias, pid_shift;

  // product stage: error and the three gain products
  assign err  = {setpoint[qapm_pkg::ANG_W-1], setpoint} - {angle[qapm_pkg::ANG_W-1], angle};
  assign kp_e = $signed({1'b0, gains.kp}) * err;
  assign ki_e = $signed({1'b0, gains.ki}) * err;
  assign kd_e = $signed({1'b0, gains.kd}) * err;

  always_ff @(posedge clk) begin
    if (load_prod) begin
      err_r  <= err;
      kp_e_r <= kp_e;
      ki_e_r <= ki_e;
      kd_e_r <= kd_e;
    end
  end

  // kd times the previous error, kept current against the live gain
  assign kdl_prod = $signed({1'b0, gains.kd}) * last_err_r;
  assign kdl_nxt  = commit ? kd_e_r : kdl_prod;

  // integrator with saturation at 40 bits
  always_comb begin
    integ_sum = (IW+3)'(integ_r) + (IW+3)'(ki_e_r);
    if (integ_sum[IW+2:IW-1] == {4{integ_sum[IW+2]}}) begin
      integ_nxt = integ_sum[IW-1:0];
    end else if (integ_sum[IW+2]) begin
      integ_nxt = {1'b1, {(IW-1){1'b0}}};
    end else begin
      integ_nxt = {1'b0, {(IW-1){1'b1}}};
    end
  end

  // P + I - D, truncated toward zero to whole microseconds, saturated
  always_comb begin
    pid_sum   = SW'(kp_e_r) + SW'(integ_nxt) - SW'(kd_e_r) + SW'(kdl_r);
    pid_bias  = pid_sum[SW-1] ? SW'((64'd1 << FW) - 64'd1) : '0;
    pid_shift = (pid_sum + pid_bias) >>> FW;
    if (pid_shift[SW-1:PW-1] == {(SW-PW+1){pid_shift[SW-1]}}) begin
      pid_nxt = pid_shift[PW-1:0];
    end else if (pid_shift[SW-1]) begin
      pid_nxt = {1'b1, {(PW-1){1'b0}}};
    end else begin
      pid_nxt = {1'b0, {(PW-1){1'b1}}};
    end
  end

  // axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
      kdl_r      <= '0;
      pid_r      <= '0;
    end else begin
      kdl_r <= kdl_nxt;
      if (commit) begin
        integ_r    <= integ_nxt;
        last_err_r <= err_r;
        pid_r      <= pid_nxt;
      end
    end
  end

  assign pid_out = pid_r;

endmodule

>>> rtl/qapm_mixer.sv
// ----------------------------------------------------------------------------
// qapm_mixer
// X-frame motor mixer with low-throttle cutoff and pulse range clamp,
// feeding the result register.
// ----------------------------------------------------------------------------
module qapm_mixer (
  input  logic                               clk,
  input  logic                               load,
  input  logic [qapm_pkg::THR_W-1:0]         throttle,
  input  logic                               updated,
  input  logic signed [qapm_pkg::PID_W-1:0]  pid_pitch,
  input  logic signed [qapm_pkg::PID_W-1:0]  pid_roll,
  input  logic signed [qapm_pkg::PID_W-1:0]  pid_yaw,
  output logic [qapm_pkg::MOTOR_W-1:0]       motor_one,
  output logic [qapm_pkg::MOTOR_W-1:0]       motor_two,
  output logic [qapm_pkg::MOTOR_W-1:0]       motor_three,
  output logic [qapm_pkg::MOTOR_W-1:0]       motor_four,
  output logic                               control_updated
);

  localparam int MW = qapm_pkg::MIX_W;

  logic signed [MW-1:0] thr, op, orl, oy, vel_a, vel_b;
  logic                 low;
  logic [qapm_pkg::MOTOR_W-1:0] m1_r, m2_r, m3_r, m4_r;
  logic                         upd_r;

  // base plus/minus yaw, then pitch or roll
  assign thr   = $signed(MW'(throttle));
  assign op    = MW'(pid_pitch);
  assign orl   = MW'(pid_roll);
  assign oy    = MW'(pid_yaw);
  assign vel_a = thr + oy;
  assign vel_b = thr - oy;
  assign low   = throttle < qapm_pkg::THROTTLE_ARM;

  always_ff @(posedge clk) begin
    if (load) begin
      m1_r  <= qapm_pkg::motor_clamp(vel_a - op, low);
      m2_r  <= qapm_pkg::motor_clamp(vel_b - orl, low);
      m3_r  <= qapm_pkg::motor_clamp(vel_a + op, low);
      m4_r  <= qapm_pkg::motor_clamp(vel_b + orl, low);
      upd_r <= updated;
    end
  end

  assign motor_one       = m1_r;
  assign motor_two       = m2_r;
  assign motor_three     = m3_r;
  assign motor_four      = m4_r;
  assign control_updated = upd_r;

endmodule
